### hw/rtl/tccs_pkg.sv
// ----------------------------------------------------------------------------
// tccs_pkg
// Shared constants, types and helpers of the text console cursor/scroll unit.
// ----------------------------------------------------------------------------
package tccs_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int COPY_COUNT = COLUMNS * (ROWS - 1);

    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int IDX_W  = 11;
    localparam int CELL_W = 16;
    localparam int ACT_W  = 2;

    typedef logic [ROW_W-1:0]  t_row;
    typedef logic [COL_W-1:0]  t_col;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [CELL_W-1:0] t_cell;
    typedef logic [ACT_W-1:0]  t_action;
    typedef logic [7:0]        t_byte;

    localparam t_action ACT_PUT  = 2'd0;
    localparam t_action ACT_DEL  = 2'd1;
    localparam t_action ACT_READ = 2'd2;

    localparam t_byte RESET_ATTR   = 8'd12;
    localparam t_byte NEWLINE_CODE = 8'd10;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;
        logic take;
        logic exec;
        logic cap_cell;
        logic copy;
        logic blank;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_read;
        logic need_scroll;
        logic clr_done;
        logic copy_done;
        logic blank_done;
        logic out_free;
    } t_sts;

    function automatic t_idx cell_addr(input t_row row, input t_col col);
        return IDX_W'(row) * IDX_W'(COLUMNS) + IDX_W'(col);
    endfunction

endpackage

### hw/rtl/tccs_in_if.sv
// ----------------------------------------------------------------------------
// tccs_in_if
// Command channel: one beat carries one console action.
// ----------------------------------------------------------------------------
interface tccs_in_if;
    logic                 valid;
    logic                 ready;
    tccs_pkg::t_action    action;
    tccs_pkg::t_byte      char_code;
    logic                 mark_waterline;
    tccs_pkg::t_idx       cell_index;

    modport source (output valid, action, char_code, mark_waterline, cell_index,
                    input ready);
    modport sink   (input valid, action, char_code, mark_waterline, cell_index,
                    output ready);
endinterface

### hw/rtl/tccs_out_if.sv
// ----------------------------------------------------------------------------
// tccs_out_if
// Response channel: one beat carries the cursor state and a read cell.
// ----------------------------------------------------------------------------
interface tccs_out_if;
    logic              valid;
    logic              ready;
    tccs_pkg::t_row    cursor_row;
    tccs_pkg::t_col    cursor_col;
    tccs_pkg::t_idx    cursor_position;
    tccs_pkg::t_cell   cell_value;
    tccs_pkg::t_col    waterline_col;

    modport source (output valid, cursor_row, cursor_col, cursor_position, cell_value,
                    waterline_col, input ready);
    modport sink   (input valid, cursor_row, cursor_col, cursor_position, cell_value,
                    waterline_col, output ready);
endinterface

### hw/rtl/tccs_ram.sv
// ----------------------------------------------------------------------------
// tccs_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tccs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/tccs_ctrl.sv
// ----------------------------------------------------------------------------
// tccs_ctrl
// Sequencer: clearing pass, action execution, read wait, scroll copy/blank.
// ----------------------------------------------------------------------------
module tccs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  tccs_pkg::t_sts i_sts,
    output tccs_pkg::t_cmd o_cmd
);
    import tccs_pkg::*;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;
    localparam logic [2:0] S_RWAIT  = 3'd3;
    localparam logic [2:0] S_SCOPY  = 3'd4;
    localparam logic [2:0] S_SBLANK = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    t_cmd       cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_CLEAR: begin
                cmd.clear = 1'b1;
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                cmd.take = i_in_valid;
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                cmd.exec = 1'b1;
                priority if (i_sts.is_read)     n_state = S_RWAIT;
                else if (i_sts.need_scroll)     n_state = S_SCOPY;
                else                            n_state = S_DONE;
            end
            S_RWAIT: begin
                cmd.cap_cell = 1'b1;
                n_state      = S_DONE;
            end
            S_SCOPY: begin
                cmd.copy = 1'b1;
                if (i_sts.copy_done) n_state = S_SBLANK;
            end
            S_SBLANK: begin
                cmd.blank = 1'b1;
                if (i_sts.blank_done) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    cmd.load_out = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = cmd;

    a_exec_plain_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && !i_sts.is_read && !i_sts.need_scroll) |=> r_state == S_DONE)
        else $error("plain action did not go straight to result");

    a_copy_then_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCOPY && i_sts.copy_done) |=> r_state == S_SBLANK)
        else $error("scroll copy did not hand over to bottom row blanking");

    a_load_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> i_sts.out_free)
        else $error("result loaded over an untaken result");

    a_no_take_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.clear || cmd.copy || cmd.blank) |-> !o_in_ready)
        else $error("command accepted during a screen sweep");

endmodule

### hw/rtl/tccs_dp.sv
// ----------------------------------------------------------------------------
// tccs_dp
// Datapath: cursor and waterline registers, screen RAM, sweep counter and
// result register.
// ----------------------------------------------------------------------------
module tccs_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tccs_pkg::t_cmd    i_cmd,
    output tccs_pkg::t_sts    o_sts,
    input  logic              i_cfg_we,
    input  tccs_pkg::t_byte   i_cfg_wdata,
    input  tccs_pkg::t_action i_action,
    input  tccs_pkg::t_byte   i_char_code,
    input  logic              i_mark_waterline,
    input  tccs_pkg::t_idx    i_cell_index,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output tccs_pkg::t_row    o_cursor_row,
    output tccs_pkg::t_col    o_cursor_col,
    output tccs_pkg::t_idx    o_cursor_position,
    output tccs_pkg::t_cell   o_cell_value,
    output tccs_pkg::t_col    o_waterline_col
);
    import tccs_pkg::*;

    // Latched command beat.
    t_action r_action;
    t_byte   r_char;
    logic    r_mark;
    t_idx    r_cidx;

    t_row    r_row, n_row;
    t_col    r_col, n_col;
    t_col    r_wl,  n_wl;
    t_byte   r_attr;
    t_idx    r_sc;
    logic    r_cp_valid;
    t_idx    r_cp_addr;
    t_cell   r_cell;

    logic    r_out_valid;
    t_row    r_out_row;
    t_col    r_out_col;
    t_idx    r_out_pos;
    t_cell   r_out_cell;
    t_col    r_out_wl;

    t_idx    cur_idx;
    t_col    col_inc;
    logic    is_put, is_nl, wrap, adv_row, at_bottom, del_ok;
    logic    ram_we;
    t_idx    ram_waddr, ram_raddr;
    t_cell   ram_wdata, ram_rdata;
    logic    out_free;

    assign cur_idx   = cell_addr(r_row, r_col);
    assign col_inc   = r_col + COL_W'(1);
    assign is_put    = (r_action == ACT_PUT);
    assign is_nl     = (r_char == NEWLINE_CODE);
    assign wrap      = (col_inc == COL_W'(COLUMNS));
    assign adv_row   = is_put && (is_nl || wrap);
    assign at_bottom = (r_row == ROW_W'(ROWS - 1));
    assign del_ok    = (r_action == ACT_DEL) && (r_col != '0) && (r_col > r_wl);
    assign out_free  = !r_out_valid || i_out_ready;

    // Cursor and waterline update for one action.
    always_comb begin
        n_row = r_row;
        n_col = r_col;
        n_wl  = r_wl;
        if (i_cmd.exec) begin
            if (is_put) begin
                if (adv_row) begin
                    n_col = '0;
                    if (!at_bottom) n_row = r_row + ROW_W'(1);
                end else begin
                    n_col = col_inc;
                end
                if (r_mark) n_wl = adv_row ? '0 : col_inc;
            end else if (del_ok) begin
                n_col = r_col - COL_W'(1);
            end
        end
    end

    // Screen write port: the sweeps never overlap an action write.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = cur_idx;
        ram_wdata = {r_attr, 8'h00};
        priority if (i_cmd.clear) begin
            ram_we    = 1'b1;
            ram_waddr = r_sc;
            ram_wdata = {RESET_ATTR, 8'h00};
        end else if (r_cp_valid) begin
            ram_we    = 1'b1;
            ram_waddr = r_cp_addr;
            ram_wdata = ram_rdata;
        end else if (i_cmd.blank) begin
            ram_we    = 1'b1;
            ram_waddr = r_sc;
        end else if (i_cmd.exec && is_put && !is_nl) begin
            ram_we    = 1'b1;
            ram_wdata = {r_attr, r_char};
        end else if (i_cmd.exec && del_ok) begin
            ram_we    = 1'b1;
            ram_waddr = cur_idx - IDX_W'(1);
        end
    end

    // The copy reads one row ahead of where it writes.
    assign ram_raddr = i_cmd.copy ? (r_sc + IDX_W'(COLUMNS)) : r_cidx;

    tccs_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_action <= i_action;
            r_char   <= i_char_code;
            r_mark   <= i_mark_waterline;
            r_cidx   <= i_cell_index;
        end
        r_cp_addr <= r_sc;
        if (i_cmd.exec) begin
            r_cell <= '0;
        end else if (i_cmd.cap_cell && (r_cidx < IDX_W'(CELL_COUNT))) begin
            r_cell <= ram_rdata;
        end
        if (i_cmd.load_out) begin
            r_out_row  <= r_row;
            r_out_col  <= r_col;
            r_out_pos  <= cur_idx;
            r_out_cell <= r_cell;
            r_out_wl   <= r_wl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row       <= '0;
            r_col       <= '0;
            r_wl        <= '0;
            r_attr      <= RESET_ATTR;
            r_sc        <= '0;
            r_cp_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_row      <= n_row;
            r_col      <= n_col;
            r_wl       <= n_wl;
            r_cp_valid <= i_cmd.copy && (r_sc != IDX_W'(COPY_COUNT));
            if (i_cfg_we) r_attr <= i_cfg_wdata;
            if (i_cmd.exec) begin
                r_sc <= '0;
            end else if (i_cmd.clear || i_cmd.blank ||
                         (i_cmd.copy && (r_sc != IDX_W'(COPY_COUNT)))) begin
                r_sc <= r_sc + IDX_W'(1);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.is_read     = (r_action == ACT_READ);
    assign o_sts.need_scroll = adv_row && at_bottom;
    assign o_sts.clr_done    = (r_sc == IDX_W'(CELL_COUNT - 1));
    assign o_sts.copy_done   = (r_sc == IDX_W'(COPY_COUNT));
    assign o_sts.blank_done  = (r_sc == IDX_W'(CELL_COUNT - 1));
    assign o_sts.out_free    = out_free;

    assign o_out_valid       = r_out_valid;
    assign o_cursor_row      = r_out_row;
    assign o_cursor_col      = r_out_col;
    assign o_cursor_position = r_out_pos;
    assign o_cell_value      = r_out_cell;
    assign o_waterline_col   = r_out_wl;

endmodule

### hw/rtl/text_console_cursor_scroll_unit.sv
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_unit
// Text console engine: put, delete and read over a screen RAM with cursor,
// line wrap, waterline and scroll-up.
// ----------------------------------------------------------------------------
//  Channel   Dir   Handshake        Contents
//  i_cmd     in    valid/ready      action, char_code, mark_waterline, cell_index
//  o_rsp     out   valid/ready      cursor_row/col/position, cell_value, waterline
//  i_cfg_*   in    write enable     text attribute byte
//
//  A put or delete passes through accept, execute and result load; a read
//  adds a wait state for the registered screen RAM read.
//  A put that moves past the last row adds a pipelined row copy of 1920
//  cells through the RAM read and write ports plus blanking of 80 cells.
//  After reset a clearing pass over 2000 cells fills the screen; no beat is taken.
//  One beat is in flight at a time; a waiting result does not block the next
//  beat, which stalls only at its own result load.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  tccs_pkg::t_byte i_cfg_wdata,
    tccs_in_if.sink         i_cmd,
    tccs_out_if.source      o_rsp
);
    import tccs_pkg::*;

    t_cmd cmd;
    t_sts sts;

    tccs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .o_in_ready (i_cmd.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tccs_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_action          (i_cmd.action),
        .i_char_code       (i_cmd.char_code),
        .i_mark_waterline  (i_cmd.mark_waterline),
        .i_cell_index      (i_cmd.cell_index),
        .i_out_ready       (o_rsp.ready),
        .o_out_valid       (o_rsp.valid),
        .o_cursor_row      (o_rsp.cursor_row),
        .o_cursor_col      (o_rsp.cursor_col),
        .o_cursor_position (o_rsp.cursor_position),
        .o_cell_value      (o_rsp.cell_value),
        .o_waterline_col   (o_rsp.waterline_col)
    );

endmodule
